/* rtl/core/mcfst_pkg.sv */
// Shared types, constants and the control store of the fixed-step ticker.
package mcfst_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = 2;
  localparam int STEP_W     = 20;
  localparam int DT_W       = 23;
  localparam int IN_W       = 24;
  localparam int CNT_W      = 24;
  localparam int BLEND_W    = 17;
  localparam int MASK_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int PC_W       = 4;
  localparam int ITER_W     = 5;

  localparam logic [CH_W-1:0]    CH_LAST     = CH_W'(CHANNELS - 1);
  localparam logic [DT_W-1:0]    HARD_CAP_US = DT_W'(500000);
  localparam logic [BLEND_W-1:0] BLEND_ONE   = BLEND_W'(65536);
  localparam logic [ITER_W-1:0]  ITER_CHAN   = ITER_W'(CNT_W);
  localparam logic [ITER_W-1:0]  ITER_BLEND  = ITER_W'(16);

  localparam logic OP_CLAMPED = 1'b0;
  localparam logic OP_EXACT   = 1'b1;
  localparam logic KIND_CHAN  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP0   = 3'd0,
    REG_STEP1   = 3'd1,
    REG_STEP2   = 3'd2,
    REG_STEP3   = 3'd3,
    REG_ENABLE  = 3'd4,
    REG_LONGEST = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_DIV_CH,
    ACT_DIV_STEP,
    ACT_EMIT_CH,
    ACT_EMIT_ZERO,
    ACT_NEXT,
    ACT_DIV_BLEND,
    ACT_EMIT_FINAL
  } act_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_CH_OFF,
    C_STEP_ZERO,
    C_DIV_MORE,
    C_CH_MORE,
    C_BEST_ZERO
  } cond_t;

  typedef enum logic [PC_W-1:0] {
    P_IDLE       = 4'd0,
    P_CHECK_EN   = 4'd1,
    P_CHECK_STEP = 4'd2,
    P_DIV_LOAD   = 4'd3,
    P_DIV_RUN    = 4'd4,
    P_EMIT       = 4'd5,
    P_NEXT       = 4'd6,
    P_BLEND_LOAD = 4'd7,
    P_BLEND_RUN  = 4'd8,
    P_FINAL      = 4'd9,
    P_EMIT_ZERO  = 4'd10
  } pc_t;

  typedef struct packed {
    act_t  act;
    hold_t hold;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  typedef struct packed {
    ctrl_word_t word;
    logic       exec;
  } seq_ctl_t;

  typedef struct packed {
    logic ch_off;
    logic step_zero;
    logic div_more;
    logic ch_more;
    logic best_zero;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic               kind;
    logic [CH_W-1:0]    channel;
    logic [CNT_W-1:0]   fire_count;
    logic [DT_W-1:0]    fire_time_us;
    logic [BLEND_W-1:0] blend_q16;
    logic               last;
  } out_item_t;

  // Control store: the branch is taken when cond holds, else the step counter advances.
  function automatic ctrl_word_t ucode(pc_t pc);
    ctrl_word_t w;
    case (pc)
      P_IDLE:       w = '{ACT_ACCEPT,     HOLD_IN,   C_NEVER,     P_IDLE};
      P_CHECK_EN:   w = '{ACT_NONE,       HOLD_NONE, C_CH_OFF,    P_NEXT};
      P_CHECK_STEP: w = '{ACT_NONE,       HOLD_NONE, C_STEP_ZERO, P_EMIT_ZERO};
      P_DIV_LOAD:   w = '{ACT_DIV_CH,     HOLD_NONE, C_NEVER,     P_IDLE};
      P_DIV_RUN:    w = '{ACT_DIV_STEP,   HOLD_NONE, C_DIV_MORE,  P_DIV_RUN};
      P_EMIT:       w = '{ACT_EMIT_CH,    HOLD_OUT,  C_NEVER,     P_IDLE};
      P_NEXT:       w = '{ACT_NEXT,       HOLD_NONE, C_CH_MORE,   P_CHECK_EN};
      P_BLEND_LOAD: w = '{ACT_DIV_BLEND,  HOLD_NONE, C_BEST_ZERO, P_FINAL};
      P_BLEND_RUN:  w = '{ACT_DIV_STEP,   HOLD_NONE, C_DIV_MORE,  P_BLEND_RUN};
      P_FINAL:      w = '{ACT_EMIT_FINAL, HOLD_OUT,  C_ALWAYS,    P_IDLE};
      P_EMIT_ZERO:  w = '{ACT_EMIT_ZERO,  HOLD_OUT,  C_ALWAYS,    P_NEXT};
      default:      w = '{ACT_NONE,       HOLD_NONE, C_ALWAYS,    P_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/mcfst_in_if.sv */
// Advance request channel: mode and elapsed time.
interface mcfst_in_if import mcfst_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic signed [IN_W-1:0] elapsed_us;

  modport source (output valid, operation, elapsed_us, input ready);
  modport sink   (input valid, operation, elapsed_us, output ready);
endinterface

/* rtl/core/mcfst_out_if.sv */
// Report channel: channel firings and the final blend fraction.
interface mcfst_out_if import mcfst_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CH_W-1:0]    channel;
  logic [CNT_W-1:0]   fire_count;
  logic [DT_W-1:0]    fire_time_us;
  logic [BLEND_W-1:0] blend_q16;
  logic               last;

  modport source (output valid, kind, channel, fire_count, fire_time_us, blend_q16, last,
                  input ready);
  modport sink   (input valid, kind, channel, fire_count, fire_time_us, blend_q16, last,
                  output ready);
endinterface

/* rtl/core/multi_channel_fixed_step_ticker_unit.sv */
// Top level of the multi-channel fixed-step ticker.
// Each accepted advance is conditioned (negatives cleared; in clamped mode capped at five
// times longest_step when that is nonzero, then at 500000 us) and the four channels are
// visited in index order, giving one report per enabled channel and then a final report
// that carries the Q1.16 blend fraction and last. One advance is worked at a time by a
// microcoded sequencer over a single restoring divider that retires one quotient bit per
// cycle, and that divider sets the rate: each enabled channel with a nonzero step takes a
// full divide, enabled step-zero and disabled channels do not use the divider, and the
// blend divide is skipped when no enabled channel has a nonzero step. The next advance is
// accepted while the final report still waits in the output register. Configuration
// writes take effect on the next cycle and belong only between advances.
module multi_channel_fixed_step_ticker_unit import mcfst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mcfst_in_if.sink              in_ch,
  mcfst_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  seq_ctl_t  ctl;
  stat_t     stat;
  out_item_t item;
  logic      item_valid;

  mcfst_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  mcfst_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_operation  (in_ch.operation),
    .in_elapsed_us (in_ch.elapsed_us),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_ch.ready),
    .out_valid     (item_valid),
    .out_item      (item),
    .stat          (stat)
  );

  assign in_ch.ready         = ctl.word.hold == HOLD_IN;
  assign out_ch.valid        = item_valid;
  assign out_ch.kind         = item.kind;
  assign out_ch.channel      = item.channel;
  assign out_ch.fire_count   = item.fire_count;
  assign out_ch.fire_time_us = item.fire_time_us;
  assign out_ch.blend_q16    = item.blend_q16;
  assign out_ch.last         = item.last;

endmodule

/* rtl/core/mcfst_div.sv */
// Restoring divider, one quotient bit per cycle while iterate is high, with a preloadable partial remainder.
module mcfst_div import mcfst_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              iterate,
  input  logic [STEP_W-1:0] load_rem,
  input  logic [CNT_W-1:0]  load_dvd,
  input  logic [STEP_W-1:0] load_div,
  input  logic [ITER_W-1:0] load_iter,
  output logic [CNT_W-1:0]  quo,
  output logic [STEP_W-1:0] rem,
  output logic              more
);

  logic [STEP_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] div_r, div_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   diff;
  logic              fits;

  always_comb begin
    trial = {rem_r, dvd_r[CNT_W-1]};
    diff  = trial - {1'b0, div_r};
    fits  = trial >= {1'b0, div_r};
  end

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    iter_nxt = iter_r;
    if (load) begin
      rem_nxt  = load_rem;
      dvd_nxt  = load_dvd;
      quo_nxt  = '0;
      div_nxt  = load_div;
      iter_nxt = load_iter;
    end else if (iterate) begin
      // a trial that does not fit is below the divisor, so it stays within the remainder width
      rem_nxt  = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      dvd_nxt  = {dvd_r[CNT_W-2:0], 1'b0};
      quo_nxt  = {quo_r[CNT_W-2:0], fits};
      iter_nxt = iter_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    if (!rst_n) begin
      iter_r <= '0;
    end else begin
      iter_r <= iter_nxt;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign more = iter_r != ITER_W'(1);

endmodule

/* rtl/core/mcfst_seq.sv */
// Microcode sequencer: step counter, control store lookup, holds and conditional jumps.
module mcfst_seq import mcfst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  stat_t    stat,
  output seq_ctl_t ctl
);

  pc_t        pc_r, pc_nxt;
  ctrl_word_t word;
  logic       held;
  logic       taken;

  // output decode
  always_comb begin
    word = ucode(pc_r);
    case (word.hold)
      HOLD_IN:  held = !in_valid;
      HOLD_OUT: held = stat.out_full;
      default:  held = 1'b0;
    endcase
    ctl.word = word;
    ctl.exec = !held;
  end

  // next step
  always_comb begin
    case (word.cond)
      C_ALWAYS:    taken = 1'b1;
      C_CH_OFF:    taken = stat.ch_off;
      C_STEP_ZERO: taken = stat.step_zero;
      C_DIV_MORE:  taken = stat.div_more;
      C_CH_MORE:   taken = stat.ch_more;
      C_BEST_ZERO: taken = stat.best_zero;
      default:     taken = 1'b0;
    endcase
    if (held) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_t'(pc_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= P_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* rtl/core/mcfst_dp.sv */
// Datapath: registers, time conditioning, accumulators, divider and the report register.
module mcfst_dp import mcfst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  seq_ctl_t               ctl,
  input  logic                   in_operation,
  input  logic signed [IN_W-1:0] in_elapsed_us,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   out_ready,
  output logic                   out_valid,
  output out_item_t              out_item,
  output stat_t                  stat
);

  logic [STEP_W-1:0] step_r [CHANNELS];
  logic [MASK_W-1:0] enable_r;
  logic [STEP_W-1:0] longest_r;
  logic [STEP_W-1:0] acc_r [CHANNELS];
  logic [STEP_W-1:0] acc_nxt [CHANNELS];
  logic [DT_W-1:0]   dt_r, dt_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [STEP_W-1:0] best_step_r, best_step_nxt;
  logic [STEP_W-1:0] best_acc_r, best_acc_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [DT_W-1:0]   dt_pos;
  logic [DT_W-1:0]   max_dt;
  logic [DT_W-1:0]   dt_soft;
  logic [DT_W-1:0]   dt_cap;
  logic [DT_W-1:0]   dt_in;
  logic [STEP_W-1:0] step_cur;
  logic [CNT_W-1:0]  sum;
  logic [BLEND_W-1:0] blend;

  logic              div_load;
  logic              div_iter;
  logic [STEP_W-1:0] div_load_rem;
  logic [CNT_W-1:0]  div_load_dvd;
  logic [STEP_W-1:0] div_load_div;
  logic [ITER_W-1:0] div_load_iter;
  logic [CNT_W-1:0]  div_quo;
  logic [STEP_W-1:0] div_rem;
  logic              div_more;

  // time conditioning: negatives to zero, then catch-up and hard caps in clamped mode
  always_comb begin
    dt_pos  = in_elapsed_us[IN_W-1] ? '0 : in_elapsed_us[DT_W-1:0];
    max_dt  = DT_W'({longest_r, 2'b00}) + DT_W'(longest_r);
    dt_soft = (max_dt != '0 && dt_pos > max_dt) ? max_dt : dt_pos;
    dt_cap  = (dt_soft > HARD_CAP_US) ? HARD_CAP_US : dt_soft;
    dt_in   = (in_operation == OP_EXACT) ? dt_pos : dt_cap;
  end

  always_comb begin
    step_cur = step_r[ch_r];
    sum      = CNT_W'(acc_r[ch_r]) + CNT_W'(dt_r);
    if (best_step_r == '0) begin
      blend = '0;
    end else if (div_quo > CNT_W'(BLEND_ONE)) begin
      blend = BLEND_ONE;
    end else begin
      blend = div_quo[BLEND_W-1:0];
    end
  end

  always_comb begin
    div_load      = ctl.exec && (ctl.word.act == ACT_DIV_CH || ctl.word.act == ACT_DIV_BLEND);
    div_iter      = ctl.exec && ctl.word.act == ACT_DIV_STEP;
    if (ctl.word.act == ACT_DIV_BLEND) begin
      // resume from the remainder and shift in sixteen fraction bits
      div_load_rem  = best_acc_r;
      div_load_dvd  = '0;
      div_load_div  = best_step_r;
      div_load_iter = ITER_BLEND;
    end else begin
      div_load_rem  = '0;
      div_load_dvd  = sum;
      div_load_div  = step_cur;
      div_load_iter = ITER_CHAN;
    end
  end

  mcfst_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (div_load),
    .iterate   (div_iter),
    .load_rem  (div_load_rem),
    .load_dvd  (div_load_dvd),
    .load_div  (div_load_div),
    .load_iter (div_load_iter),
    .quo       (div_quo),
    .rem       (div_rem),
    .more      (div_more)
  );

  always_comb begin
    acc_nxt       = acc_r;
    dt_nxt        = dt_r;
    ch_nxt        = ch_r;
    best_step_nxt = best_step_r;
    best_acc_nxt  = best_acc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctl.exec) begin
      case (ctl.word.act)
        ACT_ACCEPT: begin
          dt_nxt        = dt_in;
          ch_nxt        = '0;
          best_step_nxt = '0;
          best_acc_nxt  = '0;
        end
        ACT_EMIT_CH: begin
          acc_nxt[ch_r] = div_rem;
          if (step_cur > best_step_r) begin
            best_step_nxt = step_cur;
            best_acc_nxt  = div_rem;
          end
          out_nxt       = '{KIND_CHAN, ch_r, div_quo, DT_W'(step_cur), '0, 1'b0};
          out_valid_nxt = 1'b1;
        end
        ACT_EMIT_ZERO: begin
          out_nxt       = '{KIND_CHAN, ch_r, CNT_W'(1), dt_r, '0, 1'b0};
          out_valid_nxt = 1'b1;
        end
        ACT_NEXT: begin
          // hold on the last channel so the index never wraps
          if (ch_r != CH_LAST) begin
            ch_nxt = ch_r + 1'b1;
          end
        end
        ACT_EMIT_FINAL: begin
          out_nxt       = '{KIND_FINAL, '0, '0, '0, blend, 1'b1};
          out_valid_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dt_r       <= dt_nxt;
    best_acc_r <= best_acc_nxt;
    out_r      <= out_nxt;
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        step_r[i] <= '0;
        acc_r[i]  <= '0;
      end
      enable_r    <= '0;
      longest_r   <= '0;
      ch_r        <= '0;
      best_step_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      ch_r        <= ch_nxt;
      best_step_r <= best_step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_STEP0:   step_r[0] <= cfg_wdata[STEP_W-1:0];
          REG_STEP1:   step_r[1] <= cfg_wdata[STEP_W-1:0];
          REG_STEP2:   step_r[2] <= cfg_wdata[STEP_W-1:0];
          REG_STEP3:   step_r[3] <= cfg_wdata[STEP_W-1:0];
          REG_ENABLE:  enable_r  <= cfg_wdata[MASK_W-1:0];
          REG_LONGEST: longest_r <= cfg_wdata[STEP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    stat.ch_off    = !enable_r[ch_r];
    stat.step_zero = step_cur == '0;
    stat.div_more  = div_more;
    stat.ch_more   = ch_r != CH_LAST;
    stat.best_zero = best_step_r == '0;
    stat.out_full  = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_rem_below_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && ctl.word.act == ACT_EMIT_CH) |-> (div_rem < step_cur))
    else $error("accumulator remainder not below channel step");

  a_final_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && ctl.word.act == ACT_EMIT_FINAL) |-> (ch_r == CH_LAST))
    else $error("final report before all channels were visited");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && (ctl.word.act == ACT_EMIT_CH || ctl.word.act == ACT_EMIT_ZERO ||
                  ctl.word.act == ACT_EMIT_FINAL)) |-> (!out_valid_r || out_ready))
    else $error("report register loaded while a transaction is pending");

  a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_FINAL) |-> (out_r.blend_q16 <= BLEND_ONE && out_r.last))
    else $error("final report blend out of range or not marked last");
`endif

endmodule
